/* rtl/rfa_pkg.sv */
`default_nettype none
package rfa_pkg;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DIVZ = 2'd1;
    localparam logic [1:0] STAT_OVF  = 2'd2;

    localparam int MUL_STEPS = 4;
    localparam int DIV_STEPS = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FORM,
        ST_SIGN,
        ST_GCD,
        ST_GFIN,
        ST_DIV,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       form;
        logic       sign;
        logic       gcd_step;
        logic       gcd_fin;
        logic       div_step;
        logic       write;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic gcd_done;
    } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/rfa_ctrl.sv */
`default_nettype none
module rfa_ctrl
    import rfa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(MUL_STEPS - 1))
                    state_next = ST_FORM;
            end
            ST_FORM:
                state_next = ST_SIGN;
            ST_SIGN:
                state_next = stat.skip ? ST_WRITE : ST_GCD;
            ST_GCD:
                if (stat.gcd_done)
                    state_next = ST_GFIN;
            ST_GFIN:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                    state_next = ST_WRITE;
            end
            ST_WRITE:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cnt_reg[1:0];
            end
            ST_FORM:
                cmd.form = 1'b1;
            ST_SIGN:
                cmd.sign = 1'b1;
            ST_GCD:
                cmd.gcd_step = !stat.gcd_done;
            ST_GFIN:
                cmd.gcd_fin = 1'b1;
            ST_DIV:
                cmd.div_step = 1'b1;
            ST_WRITE:
                if (slot_free)
                begin
                    cmd.write      = 1'b1;
                    out_valid_next = 1'b1;
                end
            default:
                cmd = '0;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* rtl/rfa_dp.sv */
`default_nettype none
module rfa_dp
    import rfa_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic               clk,
    input  wire dp_cmd_t            cmd,
    output dp_stat_t                stat,
    input  wire logic        [2:0]  in_cmd,
    input  wire logic signed [31:0] a_num,
    input  wire logic        [30:0] a_den,
    input  wire logic signed [31:0] b_num,
    input  wire logic        [30:0] b_den,
    output logic signed      [31:0] res_num,
    output logic             [30:0] res_den,
    output logic             [1:0]  status,
    output logic                    less,
    output logic                    equal
);

    localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

    logic        [2:0]  op_reg;
    logic signed [31:0] an_reg, bn_reg;
    logic        [30:0] ad_reg, bd_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [63:0] n_reg, d_reg;
    logic               less_reg, equal_reg, neg_reg;
    logic        [63:0] x_reg, y_reg, mn_reg, md_reg, g_reg, rn_reg, rd_reg;
    logic        [5:0]  k_reg;
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic               bad_cmd, zden, divz, skip;
    logic        [63:0] tn, td, qn, qd;
    logic               ge_n, ge_d, neg_f, ovf;
    logic        [1:0]  sp_status;

    assign bad_cmd = op_reg > CMD_CMP;
    assign zden    = (ad_reg == '0) || (bd_reg == '0);
    assign divz    = (op_reg == CMD_DIV) && (bn_reg == '0);
    assign skip    = bad_cmd || zden || divz || (op_reg == CMD_CMP);
    assign stat.skip     = skip;
    assign stat.gcd_done = (x_reg == '0);

    always_comb
    begin
        case (cmd.mul_sel)
            2'd0:
            begin
                ma = an_reg;
                mb = $signed({1'b0, bd_reg});
            end
            2'd1:
            begin
                ma = $signed({1'b0, ad_reg});
                mb = bn_reg;
            end
            2'd2:
            begin
                ma = $signed({1'b0, ad_reg});
                mb = $signed({1'b0, bd_reg});
            end
            default:
            begin
                ma = an_reg;
                mb = bn_reg;
            end
        endcase
    end
    assign prod = ma * mb;

    assign tn   = {rn_reg[62:0], mn_reg[63]};
    assign td   = {rd_reg[62:0], md_reg[63]};
    assign ge_n = tn >= g_reg;
    assign ge_d = td >= g_reg;

    assign qn    = mn_reg;
    assign qd    = md_reg;
    assign neg_f = neg_reg && (qn != '0);
    assign ovf   = (qd > LIM - 64'd1) || (neg_f ? (qn > LIM) : (qn > LIM - 64'd1));

    always_comb
    begin
        if (bad_cmd)
            sp_status = STAT_OK;
        else if (zden || divz)
            sp_status = STAT_DIVZ;
        else
            sp_status = STAT_OK;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_cmd;
            an_reg <= a_num;
            ad_reg <= a_den;
            bn_reg <= b_num;
            bd_reg <= b_den;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                2'd0:    p0_reg <= prod;
                2'd1:    p1_reg <= prod;
                2'd2:    p2_reg <= prod;
                default: p3_reg <= prod;
            endcase
        end
        if (cmd.form)
        begin
            less_reg  <= p0_reg < p1_reg;
            equal_reg <= p0_reg == p1_reg;
            case (op_reg)
                CMD_ADD:
                begin
                    n_reg <= p0_reg + p1_reg;
                    d_reg <= p2_reg;
                end
                CMD_SUB:
                begin
                    n_reg <= p0_reg - p1_reg;
                    d_reg <= p2_reg;
                end
                CMD_MUL:
                begin
                    n_reg <= p3_reg;
                    d_reg <= p2_reg;
                end
                default:
                begin
                    n_reg <= p0_reg;
                    d_reg <= p1_reg;
                end
            endcase
        end
        if (cmd.sign)
        begin
            k_reg <= '0;
            if (d_reg < 0)
            begin
                neg_reg <= n_reg > 0;
                mn_reg  <= (n_reg > 0) ? 64'(n_reg) : 64'(-n_reg);
                x_reg   <= (n_reg > 0) ? 64'(n_reg) : 64'(-n_reg);
                md_reg  <= 64'(-d_reg);
                y_reg   <= 64'(-d_reg);
            end
            else
            begin
                neg_reg <= n_reg < 0;
                mn_reg  <= (n_reg < 0) ? 64'(-n_reg) : 64'(n_reg);
                x_reg   <= (n_reg < 0) ? 64'(-n_reg) : 64'(n_reg);
                md_reg  <= 64'(d_reg);
                y_reg   <= 64'(d_reg);
            end
        end
        if (cmd.gcd_step)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + 6'd1;
            end
            else if (!x_reg[0])
                x_reg <= x_reg >> 1;
            else if (!y_reg[0])
                y_reg <= y_reg >> 1;
            else if (x_reg >= y_reg)
                x_reg <= (x_reg - y_reg) >> 1;
            else
                y_reg <= (y_reg - x_reg) >> 1;
        end
        if (cmd.gcd_fin)
        begin
            g_reg  <= y_reg << k_reg;
            rn_reg <= '0;
            rd_reg <= '0;
        end
        if (cmd.div_step)
        begin
            mn_reg <= {mn_reg[62:0], ge_n};
            md_reg <= {md_reg[62:0], ge_d};
            rn_reg <= ge_n ? tn - g_reg : tn;
            rd_reg <= ge_d ? td - g_reg : td;
        end
        if (cmd.write)
        begin
            if (skip)
            begin
                res_num <= '0;
                res_den <= '0;
                status  <= sp_status;
                less    <= (op_reg == CMD_CMP) && !zden && less_reg;
                equal   <= (op_reg == CMD_CMP) && !zden && equal_reg;
            end
            else
            begin
                less  <= 1'b0;
                equal <= 1'b0;
                if (ovf)
                begin
                    res_num <= '0;
                    res_den <= '0;
                    status  <= STAT_OVF;
                end
                else
                begin
                    res_num <= neg_f ? $signed(32'(-qn)) : $signed(qn[31:0]);
                    res_den <= qd[30:0];
                    status  <= STAT_OK;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/rational_fraction_alu.sv */
`default_nettype none
// Exact arithmetic on signed fractions a = a_num/a_den and b = b_num/b_den.
// Input channel: in_valid/in_ready with cmd and both operands. Output channel:
// out_valid/out_ready with res_num, res_den, status, less and equal.
// One item is in work at a time; in_ready is high only while the controller
// waits for an item. A finished result sits in the output register, so the
// next item is taken and worked on while that result waits to be taken.
// Steps: load, four products on the shared 32x32 multiplier, then form and
// sign the fraction. Compare, unknown commands, zero denominators and
// divide by zero then go straight to the write step. Add, subtract,
// multiply and divide run a binary gcd over the 64-bit magnitudes, one step
// a cycle, then a check that sees it finish, a step to form the gcd, a
// restoring division by it over 64 quotient bits (numerator and denominator
// in parallel) and the write step.
// Reset clears the controller and the output valid; no result is pending.
// While the receiver stalls, the result holds and the block stops in its
// write step with the next result until the output register frees.
module rational_fraction_alu
    import rfa_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic        [2:0]  cmd,
    input  wire logic signed [31:0] a_num,
    input  wire logic        [30:0] a_den,
    input  wire logic signed [31:0] b_num,
    input  wire logic        [30:0] b_den,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed      [31:0] res_num,
    output logic             [30:0] res_den,
    output logic             [1:0]  status,
    output logic                    less,
    output logic                    equal
);

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    rfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dstat),
        .cmd       (dcmd)
    );

    rfa_dp #(.WIDTH(WIDTH)) u_dp (
        .clk     (clk),
        .cmd     (dcmd),
        .stat    (dstat),
        .in_cmd  (cmd),
        .a_num   (a_num),
        .a_den   (a_den),
        .b_num   (b_num),
        .b_den   (b_den),
        .res_num (res_num),
        .res_den (res_den),
        .status  (status),
        .less    (less),
        .equal   (equal)
    );

endmodule
`default_nettype wire

/* rtl/rfa_checker.sv */
`default_nettype none
module rfa_checker
    import rfa_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] res_num,
    input wire logic        [30:0] res_den,
    input wire logic        [1:0]  status,
    input wire logic               less,
    input wire logic               equal
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> res_num == '0 && res_den == '0 && !less && !equal)
        else $error("error result carries data");

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res_den == '0 |-> res_num == '0)
        else $error("numerator without denominator");

    a_less_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && less |-> !equal)
        else $error("less and equal both set");

endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (.*);
`default_nettype wire
